/* rtl/cnds_pkg.sv */
// cnds_pkg: shared types and constants for the class nearest distance scorer.
// No dependencies.
package cnds_pkg;
    localparam int ENTRY_DEPTH = 1024;
    localparam int AW = $clog2(ENTRY_DEPTH);
    localparam int CW = $clog2(ENTRY_DEPTH + 1);
    localparam int CLASS_COUNT = 4;
    localparam logic [16:0] DIST_INF = 17'h10000;
    localparam logic signed [33:0] SCORE_MIN = {1'b1, 33'd0};

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_READ, t_ST_SCAN, t_ST_SORT, t_ST_DIV0, t_ST_DIV1
    } t_state;

    typedef struct packed {
        logic        start;
        logic [35:0] dividend;
        logic [19:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [35:0] quotient;
    } t_div_rsp;
endpackage

/* rtl/class_nearest_distance_scorer_unit.sv */
// class_nearest_distance_scorer_unit: top level with entry table, scan sequencer
// and score/best tracking. Depends on cnds_pkg and cnds_divider.
//
// A store transaction appends one labelled point; a full table drops it
// and sets o_insert_dropped. A score transaction walks the entry table once through
// a single memory read port (one entry per cycle, N entries stored), keeping the
// minimum Chebyshev distance per class, picks the two smallest of the four minima, then
// runs the two reciprocal terms one after the other through one shared restoring
// divider; terms that need no division (empty class, zero distance) are skipped.
// One transaction is in work at a time. The result sits in an output register until
// taken, and the next transaction is accepted meanwhile; it holds back its own
// result (a store before its write, a score before its divisions) until the previous
// one has been taken.
// No clearing pass after reset.
module class_nearest_distance_scorer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [15:0]         i_point_x,
    input  logic [15:0]         i_point_y,
    input  logic [1:0]          i_outcome_class,
    input  logic                i_last_candidate,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [33:0]  o_score,
    output logic [15:0]         o_best_x,
    output logic [15:0]         o_best_y,
    output logic signed [33:0]  o_best_score,
    output logic                o_batch_done,
    output logic                o_insert_dropped
);
    cnds_pkg::t_state r_state, n_state;

    // entry table
    logic [33:0] r_mem [cnds_pkg::ENTRY_DEPTH];
    logic [33:0] r_rd;
    logic [cnds_pkg::CW-1:0] r_count, r_idx;

    // captured transaction
    logic        r_op, r_last;
    logic [15:0] r_px, r_py;
    logic [1:0]  r_cls;
    logic        r_rdv, n_rdv;
    logic [16:0] r_min [cnds_pkg::CLASS_COUNT];
    logic [16:0] r_d0, r_d1;
    logic [35:0] r_t0;

    logic        r_batch_open;
    logic [15:0] r_bx, r_by;
    logic signed [33:0] r_bs;

    logic w_acc_in, w_acc_out, w_last_rd, w_full, w_out_free;
    logic w_need0, w_need1, w_div0_end, w_div1_end, w_put_store, w_put_score, w_take;
    logic [16:0] w_a, w_b, w_c, w_e, w_lo, w_hi;
    logic [15:0] w_dx, w_dy, w_d;
    logic [1:0]  w_ec;
    logic signed [33:0] w_score;
    cnds_pkg::t_div_req w_req;
    cnds_pkg::t_div_rsp w_rsp;

    cnds_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_acc_in   = i_valid && !o_stall;
    assign w_acc_out  = o_valid && !i_stall;
    assign o_stall    = (r_state != cnds_pkg::t_ST_IDLE);
    assign w_last_rd  = (r_idx == r_count);
    assign w_full     = (r_count == cnds_pkg::CW'(cnds_pkg::ENTRY_DEPTH));
    // output register empty at the next edge
    assign w_out_free = !o_valid || w_acc_out;

    // a term needs the divider unless its distance is infinite; zero d0 saturates
    assign w_need0    = (r_d0 != 17'd0) && (r_d0 != cnds_pkg::DIST_INF);
    assign w_need1    = (r_d0 != 17'd0) && (r_d1 != cnds_pkg::DIST_INF);
    assign w_div0_end = (r_state == cnds_pkg::t_ST_DIV0) && (!w_need0 || w_rsp.done);
    assign w_div1_end = (r_state == cnds_pkg::t_ST_DIV1) && (!w_need1 || w_rsp.done);

    assign w_put_store = (r_state == cnds_pkg::t_ST_READ) && (r_op == cnds_pkg::OP_STORE)
                         && w_out_free;
    assign w_put_score = w_div1_end;

    // next read is valid while the scan still has entries left
    assign n_rdv = ((r_state == cnds_pkg::t_ST_READ) && (r_op == cnds_pkg::OP_SCORE)
                    && (r_count != '0))
                   || ((r_state == cnds_pkg::t_ST_SCAN) && !w_last_rd);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cnds_pkg::t_ST_IDLE: if (w_acc_in) n_state = cnds_pkg::t_ST_READ;
            cnds_pkg::t_ST_READ: begin
                if (r_op == cnds_pkg::OP_SCORE) n_state = cnds_pkg::t_ST_SCAN;
                else if (w_out_free)          n_state = cnds_pkg::t_ST_IDLE;
            end
            cnds_pkg::t_ST_SCAN: if (w_last_rd && !r_rdv) n_state = cnds_pkg::t_ST_SORT;
            // the divisions start only once the output register is sure to be free
            cnds_pkg::t_ST_SORT: if (w_out_free) n_state = cnds_pkg::t_ST_DIV0;
            cnds_pkg::t_ST_DIV0: if (w_div0_end) n_state = cnds_pkg::t_ST_DIV1;
            cnds_pkg::t_ST_DIV1: if (w_div1_end) n_state = cnds_pkg::t_ST_IDLE;
            default:             n_state = cnds_pkg::t_ST_IDLE;
        endcase
    end

    // sort network result: two smallest of four
    always_comb begin
        w_a = (r_min[0] <= r_min[1]) ? r_min[0] : r_min[1];
        w_b = (r_min[0] <= r_min[1]) ? r_min[1] : r_min[0];
        w_c = (r_min[2] <= r_min[3]) ? r_min[2] : r_min[3];
        w_e = (r_min[2] <= r_min[3]) ? r_min[3] : r_min[2];
        w_lo = (w_a <= w_c) ? w_a : w_c;
        if (w_a <= w_c) w_hi = (w_b <= w_c) ? w_b : w_c;
        else            w_hi = (w_a <= w_e) ? w_a : w_e;
    end

    // divider requests: 2^32/d0 for the first term, 9*2^32/(10*d1) for the second
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = 36'd1 << 32;
        w_req.divisor  = {3'd0, w_lo};
        if (r_state == cnds_pkg::t_ST_SORT) begin
            w_req.start = w_out_free && (w_lo != 17'd0) && (w_lo != cnds_pkg::DIST_INF);
        end else if (w_div0_end) begin
            w_req.start    = w_need1;
            w_req.dividend = 36'd9 << 32;
            w_req.divisor  = {r_d1, 3'd0} + {2'd0, r_d1, 1'b0};
        end
    end

    // distance of the registered entry
    always_comb begin
        w_dx = (r_rd[33:18] > r_px) ? r_rd[33:18] - r_px : r_px - r_rd[33:18];
        w_dy = (r_rd[17:2] > r_py) ? r_rd[17:2] - r_py : r_py - r_rd[17:2];
        w_d  = (w_dx > w_dy) ? w_dx : w_dy;
        w_ec = r_rd[1:0];
    end

    // second term is zero when its division was skipped (no done pulse then)
    assign w_score = (r_d0 == 17'd0) ? cnds_pkg::SCORE_MIN
                   : $signed(w_rsp.done ? {1'b0, w_rsp.quotient[32:0]} : 34'd0)
                     - $signed({1'b0, r_t0[32:0]});
    assign w_take  = !r_batch_open || (w_score > r_bs);

    always_ff @(posedge i_clk) begin
        if (w_put_store && !w_full)
            r_mem[r_idx[cnds_pkg::AW-1:0]] <= {r_px, r_py, r_cls};
        r_rd <= r_mem[r_idx[cnds_pkg::AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cnds_pkg::t_ST_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_rdv        <= 1'b0;
            r_batch_open <= 1'b0;
            r_bx         <= '0;
            r_by         <= '0;
            r_bs         <= '0;
            o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdv   <= n_rdv;
            o_valid <= w_put_store || w_put_score || (o_valid && !w_acc_out);
            case (r_state)
                cnds_pkg::t_ST_IDLE: begin
                    if (w_acc_in) begin
                        r_op   <= i_operation;
                        r_px   <= i_point_x;
                        r_py   <= i_point_y;
                        r_cls  <= i_outcome_class;
                        r_last <= i_last_candidate;
                        r_idx  <= (i_operation == cnds_pkg::OP_STORE) ? r_count : '0;
                        for (int k = 0; k < cnds_pkg::CLASS_COUNT; k++)
                            r_min[k] <= cnds_pkg::DIST_INF;
                    end
                end
                cnds_pkg::t_ST_READ: begin
                    if (r_op == cnds_pkg::OP_STORE) begin
                        if (w_out_free) begin
                            o_score          <= '0;
                            o_best_x         <= r_bx;
                            o_best_y         <= r_by;
                            o_best_score     <= r_bs;
                            o_batch_done     <= 1'b0;
                            o_insert_dropped <= w_full;
                            if (!w_full)
                                r_count <= r_count + cnds_pkg::CW'(1);
                        end
                    end else if (r_count != '0) begin
                        r_idx <= r_idx + cnds_pkg::CW'(1);
                    end
                end
                cnds_pkg::t_ST_SCAN: begin
                    if (r_rdv && {1'b0, w_d} < r_min[w_ec]) r_min[w_ec] <= {1'b0, w_d};
                    if (!w_last_rd)
                        r_idx <= r_idx + cnds_pkg::CW'(1);
                end
                cnds_pkg::t_ST_SORT: begin
                    r_d0 <= w_lo;
                    r_d1 <= w_hi;
                    r_t0 <= '0;
                end
                cnds_pkg::t_ST_DIV0: if (w_rsp.done) r_t0 <= w_rsp.quotient;
                cnds_pkg::t_ST_DIV1: begin
                    if (w_div1_end) begin
                        o_score          <= w_score;
                        o_batch_done     <= r_last;
                        o_insert_dropped <= 1'b0;
                        if (w_take) begin
                            o_best_x <= r_px; o_best_y <= r_py; o_best_score <= w_score;
                        end else begin
                            o_best_x <= r_bx; o_best_y <= r_by; o_best_score <= r_bs;
                        end
                        // batch close returns the running best to its reset values
                        if (r_last) begin
                            r_bx <= '0; r_by <= '0; r_bs <= '0;
                        end else if (w_take) begin
                            r_bx <= r_px; r_by <= r_py; r_bs <= w_score;
                        end
                        r_batch_open <= !r_last;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     o_valid && i_stall |=> o_valid && $stable(o_score)
                                            && $stable(o_best_score))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     r_count <= cnds_pkg::CW'(cnds_pkg::ENTRY_DEPTH))
        else $error("entry count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     w_acc_in |=> r_state == cnds_pkg::t_ST_READ)
        else $error("accept did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     w_put_score |-> !o_valid || w_acc_out)
        else $error("score result overwrote a waiting result");
endmodule

/* rtl/cnds_divider.sv */
// cnds_divider: shared restoring divider, one quotient bit per cycle.
// Depends on cnds_pkg.
module cnds_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cnds_pkg::t_div_req i_req,
    output cnds_pkg::t_div_rsp o_rsp
);
    logic [35:0] r_q, n_q;
    logic [20:0] r_rem, n_rem;
    logic [19:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [20:0] w_trial;

    always_comb begin
        w_trial = {r_rem[19:0], r_q[35]} - {1'b0, r_div};
        if (!w_trial[20]) begin
            n_rem = w_trial;
            n_q   = {r_q[34:0], 1'b1};
        end else begin
            n_rem = {r_rem[19:0], r_q[35]};
            n_q   = {r_q[34:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd36;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("div done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_req.start |=> r_busy)
        else $error("div did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_busy |-> r_cnt != 6'd0)
        else $error("div count ran out");
endmodule

/* sim/class_nearest_distance_scorer_unit_checker.sv */
// Checker for class_nearest_distance_scorer_unit: predicts each result from the
// accepted transactions and compares it with all its fields at once. Depends on cnds_pkg.
`timescale 1ns / 100ps
module class_nearest_distance_scorer_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               i_operation,
    input  logic [15:0]        i_point_x,
    input  logic [15:0]        i_point_y,
    input  logic [1:0]         i_outcome_class,
    input  logic               i_last_candidate,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [33:0] o_score,
    input  logic [15:0]        o_best_x,
    input  logic [15:0]        o_best_y,
    input  logic signed [33:0] o_best_score,
    input  logic               o_batch_done,
    input  logic               o_insert_dropped,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_scored,
    output int                 o_dropped_seen,
    output int                 o_saturated_seen
);
    typedef struct packed {
        logic signed [33:0] score;
        logic [15:0]        bx;
        logic [15:0]        by;
        logic signed [33:0] bscore;
        logic               done;
        logic               dropped;
    } t_result;

    logic [15:0]        tbl_x [cnds_pkg::ENTRY_DEPTH];
    logic [15:0]        tbl_y [cnds_pkg::ENTRY_DEPTH];
    logic [1:0]         tbl_cls [cnds_pkg::ENTRY_DEPTH];
    int                 tbl_count;
    logic [15:0]        best_x_q, best_y_q;
    logic signed [33:0] best_score_q;
    logic               batch_live;
    t_result            expected_results[$];

    function automatic logic signed [33:0] candidate_score(logic [15:0] px, logic [15:0] py);
        logic [16:0] near [4];
        logic [16:0] dx, dy, d, v;
        logic [63:0] t0, t1;
        int j;
        for (int c = 0; c < 4; c++) near[c] = cnds_pkg::DIST_INF;
        for (int i = 0; i < tbl_count; i++) begin
            dx = tbl_x[i] > px ? tbl_x[i] - px : px - tbl_x[i];
            dy = tbl_y[i] > py ? tbl_y[i] - py : py - tbl_y[i];
            d = dx > dy ? dx : dy;
            if (d < near[tbl_cls[i]]) near[tbl_cls[i]] = d;
        end
        for (int i = 1; i < 4; i++) begin
            v = near[i];
            j = i;
            while (j > 0 && near[j-1] > v) begin
                near[j] = near[j-1];
                j--;
            end
            near[j] = v;
        end
        if (near[0] == 0) return cnds_pkg::SCORE_MIN;
        t0 = near[0] >= cnds_pkg::DIST_INF ? 64'd0 : (64'd1 << 32) / near[0];
        t1 = near[1] >= cnds_pkg::DIST_INF ? 64'd0 : (64'd9 << 32) / (64'd10 * near[1]);
        return 34'(t1 - t0);
    endfunction

    always @(posedge i_clk) begin
        t_result r, got;
        if (!i_rst_n) begin
            tbl_count <= 0;
            best_x_q = 0; best_y_q = 0; best_score_q = 0; batch_live = 0;
            o_fail_count <= 0; o_scored <= 0; o_dropped_seen <= 0; o_saturated_seen <= 0;
            o_pending <= 0;
            expected_results.delete();
        end else begin
            // output side first: a result can never come from the same-edge input
            if (o_valid && !i_stall) begin
                got = '{o_score, o_best_x, o_best_y, o_best_score, o_batch_done,
                        o_insert_dropped};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    r = expected_results.pop_front();
                    if (r !== got) begin
                        $display("%0t: mismatch expected %p actual %p", $time, r, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                r = '0;
                if (i_operation == cnds_pkg::OP_STORE) begin
                    if (tbl_count < cnds_pkg::ENTRY_DEPTH) begin
                        tbl_x[tbl_count] = i_point_x;
                        tbl_y[tbl_count] = i_point_y;
                        tbl_cls[tbl_count] = i_outcome_class;
                        tbl_count <= tbl_count + 1;
                    end else begin
                        r.dropped = 1;
                        o_dropped_seen <= o_dropped_seen + 1;
                    end
                end else begin
                    r.score = candidate_score(i_point_x, i_point_y);
                    if (r.score == cnds_pkg::SCORE_MIN)
                        o_saturated_seen <= o_saturated_seen + 1;
                    o_scored <= o_scored + 1;
                    if (!batch_live || r.score > best_score_q) begin
                        best_score_q = r.score;
                        best_x_q = i_point_x;
                        best_y_q = i_point_y;
                    end
                    batch_live = 1;
                    r.done = i_last_candidate;
                end
                r.bx = best_x_q; r.by = best_y_q; r.bscore = best_score_q;
                expected_results = {expected_results, r};
                if (r.done) begin
                    best_x_q = 0; best_y_q = 0; best_score_q = 0; batch_live = 0;
                end
            end
            o_pending <= expected_results.size();
        end
    end
endmodule

/* sim/class_nearest_distance_scorer_unit_tb.sv */
// Testbench top for class_nearest_distance_scorer_unit: drives store and score
// transactions with random idling and gives the verdict. Depends on cnds_pkg,
// the block and class_nearest_distance_scorer_unit_checker.
`timescale 1ns / 100ps
module class_nearest_distance_scorer_unit_tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_operation;
    logic [15:0]        i_point_x;
    logic [15:0]        i_point_y;
    logic [1:0]         i_outcome_class;
    logic               i_last_candidate;
    logic               o_valid;
    logic               i_stall;
    logic signed [33:0] o_score;
    logic [15:0]        o_best_x;
    logic [15:0]        o_best_y;
    logic signed [33:0] o_best_score;
    logic               o_batch_done;
    logic               o_insert_dropped;
    int                 fail_count, pending, scored, dropped_seen, saturated_seen;

    // idle percentages per phase, and a long receiver hold-off request
    int                 send_idle_pct;
    int                 recv_idle_pct;
    logic               hold_recv;
    int                 stall_cycles;
    int                 idle_cycles;
    // a few recent stored points, so candidates can land exactly on an entry
    logic [15:0]        recent_x [8];
    logic [15:0]        recent_y [8];

    class_nearest_distance_scorer_unit u_dut (.*);

    class_nearest_distance_scorer_unit_checker u_checker (
        .*,
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_scored        (scored),
        .o_dropped_seen  (dropped_seen),
        .o_saturated_seen(saturated_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall, plus a long counted hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            stall_cycles <= 0;
        end else if (hold_recv && stall_cycles < 3000) begin
            i_stall <= 1;
            stall_cycles <= stall_cycles + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: counts cycles without any accepted transaction or taken result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One transaction: optional random gap, then hold until accepted.
    task automatic send_item(logic op, logic [15:0] x, logic [15:0] y, logic [1:0] cls,
                             logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_operation = op;
        i_point_x = x;
        i_point_y = y;
        i_outcome_class = cls;
        i_last_candidate = last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic store_point(logic [15:0] x, logic [15:0] y, logic [1:0] cls);
        int k;
        k = $urandom_range(7);
        recent_x[k] = x;
        recent_y[k] = y;
        send_item(cnds_pkg::OP_STORE, x, y, cls, 0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // A batch of candidates; some land exactly on a stored point, some near one.
    task automatic score_batch(int n);
        logic [15:0] x, y;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(7);
            case ($urandom_range(3))
                0: begin x = recent_x[k]; y = recent_y[k]; end
                1: begin
                    x = recent_x[k] + 16'($urandom_range(40)) - 16'd20;
                    y = recent_y[k] + 16'($urandom_range(40)) - 16'd20;
                end
                default: begin x = 16'($urandom); y = 16'($urandom); end
            endcase
            send_item(cnds_pkg::OP_SCORE, x, y, 2'($urandom), i == n - 1);
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_operation = cnds_pkg::OP_STORE;
        i_point_x = 0;
        i_point_y = 0;
        i_outcome_class = 0;
        i_last_candidate = 0;
        hold_recv = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8; i++) begin
            recent_x[i] = 0;
            recent_y[i] = 0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: empty table, a single class, both extremes, exact hit, batch close.
        send_item(cnds_pkg::OP_SCORE, 16'h0000, 16'h0000, 2'd3, 0);
        send_item(cnds_pkg::OP_SCORE, 16'hFFFF, 16'hFFFF, 2'd0, 1);
        store_point(16'h0000, 16'h0000, 2'd0);
        send_item(cnds_pkg::OP_SCORE, 16'hFFFF, 16'h0001, 2'd1, 0);   // one class only
        send_item(cnds_pkg::OP_SCORE, 16'h0000, 16'h0000, 2'd0, 1);   // zero distance
        store_point(16'hFFFF, 16'hFFFF, 2'd3);
        store_point(16'h8000, 16'h4000, 2'd1);
        store_point(16'h5555, 16'hAAAA, 2'd2);
        send_item(cnds_pkg::OP_SCORE, 16'h8001, 16'h4000, 2'd0, 0);
        send_item(cnds_pkg::OP_SCORE, 16'hAAAA, 16'h5555, 2'd0, 0);
        send_item(cnds_pkg::OP_SCORE, 16'h0001, 16'hFFFE, 2'd0, 1);
        // store in an open batch leaves the best untouched
        send_item(cnds_pkg::OP_SCORE, 16'h1234, 16'h4321, 2'd0, 0);
        store_point(16'h1230, 16'h4320, 2'd2);
        send_item(cnds_pkg::OP_SCORE, 16'h1234, 16'h4321, 2'd0, 1);
        wait_drained();

        // Random phases: receiver-heavy idle, sender-heavy idle, then no idle.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 24 : (phase == 1 ? 71 : 0);
            recv_idle_pct = phase == 0 ? 71 : (phase == 1 ? 24 : 0);
            for (int b = 0; b < 21; b++) begin
                for (int s = $urandom_range(12); s > 0; s--)
                    store_point(16'($urandom), 16'($urandom), 2'($urandom));
                if (phase == 0 && b == 3) begin
                    // long receiver hold-off; the four candidates back up behind the held result
                    hold_recv = 1;
                    score_batch(4);
                    hold_recv = 0;
                end else begin
                    score_batch($urandom_range(1, 4));
                end
                if (b == 6) wait_drained();                // sender pauses for drain
            end
            wait_drained();
        end
        repeat (200) @(negedge i_clk);

        $display("Covered %0d scores (%0d saturated), %0d dropped stores, three idle phases.",
                 scored, saturated_seen, dropped_seen);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
